/* src/pdp_pkg.sv */
// Package for the polyline point-at-distance block: widths, command and status codes.
// No dependencies; used by polyline_point_at_distance and pdp_checker.
package pdp_pkg;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_W          = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;
endpackage

/* src/pdp_if.sv */
// Request and response channel interfaces of the polyline point-at-distance block.
// No dependencies.
interface pdp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] distance;
    modport source (output valid, command, coord_x, coord_y, distance, input ready);
    modport sink   (input valid, command, coord_x, coord_y, distance, output ready);
endinterface

interface pdp_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]         status;
    modport source (output valid, out_x, out_y, status, input ready);
    modport sink   (input valid, out_x, out_y, status, output ready);
endinterface

/* src/pdp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pdp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/polyline_point_at_distance.sv */
// Polyline point-at-distance: top level with vertex store and segment walker.
// Depends on pdp_pkg, pdp_if (pdp_req_if, pdp_rsp_if) and pdp_ram.
//
// Keeps up to MAX_VERTICES polyline vertices (signed Q16.16) in a one-port-read
// RAM and answers one response per request. Clear, append, unknown commands and
// a query on an empty line are answered as they are accepted. A query with a
// negative distance or on a single vertex reads v[0] in S_RD0 and then answers
// from S_DONE. Otherwise the walker visits the segments in order, one RAM read
// each: per segment two 32x32 squares, an add and a 33-step bit-serial square
// root. In the segment that covers the distance, each axis takes a multiply and
// a 64-step restoring division. The store needs no clearing pass after reset:
// only entries below the vertex count are used. A new request is taken when the
// walker is idle and the response register is free or being drained.
module polyline_point_at_distance #(
    parameter int MAX_VERTICES = pdp_pkg::MAX_VERTICES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pdp_req_if.sink   i_req,
    pdp_rsp_if.source o_rsp
);
    import pdp_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_LOAD0, S_LOADN, S_MX, S_MY, S_ADD,
        S_SQRT, S_TEST, S_MUL, S_ADDH, S_DIV, S_DONE
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_last;
    logic [30:0]   r_dist;
    logic [31:0]   r_acc;
    logic [31:0]   r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic [31:0]   r_mx, r_my;
    logic [63:0]   r_sq, r_prod;
    logic [65:0]   r_rad;
    logic [35:0]   r_srem;
    logic [32:0]   r_root;
    logic [5:0]    r_cnt;
    logic [30:0]   r_rem;
    logic [63:0]   r_num;
    logic [32:0]   r_drem;
    logic [31:0]   r_q;
    logic          r_axis;
    logic [31:0]   r_rx, r_ry;
    logic [1:0]    r_st;
    logic          r_ov;
    logic [31:0]   r_ox, r_oy;
    logic [1:0]    r_ost;

    logic          accept;
    logic          rsp_load;
    logic          ram_we;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;

    // sqrt step
    logic [35:0] sq_sh;
    logic [32:0] root_sh;
    logic [35:0] sq_trial;
    logic        sq_ok;
    // segment deltas between current and previous vertex
    logic [32:0] dx_cur, dy_cur, dx_rd, dy_rd;
    logic [31:0] mag_sel;
    logic        neg_sel;
    // division step
    logic [33:0] dv_rr;
    logic        dv_ok;
    logic [31:0] q_next, v0_sel, lerp;
    logic [33:0] acc_end;

    function automatic logic [31:0] abs33(input logic [32:0] v);
        logic [32:0] n;
        n = v[32] ? (33'd0 - v) : v;
        return n[31:0];
    endfunction

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign ram_we      = accept && (i_req.command == CMD_APPEND)
                         && (r_count != CW'(MAX_VERTICES));
    // response register loads on an accepted request other than a query on a non-empty line, or at the end of a walk
    assign rsp_load    = (accept && !((i_req.command == CMD_QUERY) && (r_count != '0)))
                         || ((r_state == S_DONE) && (!r_ov || o_rsp.ready));

    always_comb begin
        unique case (r_state)
            S_LOAD0: rd_addr = AW'(1);
            S_TEST:  rd_addr = r_idx + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    pdp_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_req.coord_x, i_req.coord_y}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign dx_rd  = {rd_data[63], rd_data[63:32]} - {r_prev_x[31], r_prev_x};
    assign dy_rd  = {rd_data[31], rd_data[31:0]}  - {r_prev_y[31], r_prev_y};
    assign dx_cur = {r_cur_x[31], r_cur_x} - {r_prev_x[31], r_prev_x};
    assign dy_cur = {r_cur_y[31], r_cur_y} - {r_prev_y[31], r_prev_y};

    assign sq_sh    = {r_srem[33:0], r_rad[65:64]};
    assign root_sh  = {r_root[31:0], 1'b0};
    assign sq_trial = {2'b00, root_sh, 1'b1};
    assign sq_ok    = sq_sh >= sq_trial;

    assign mag_sel = r_axis ? abs33(dy_cur) : abs33(dx_cur);
    assign neg_sel = r_axis ? dy_cur[32] : dx_cur[32];
    assign v0_sel  = r_axis ? r_prev_y : r_prev_x;
    assign dv_rr   = {r_drem, r_num[63]};
    assign dv_ok   = dv_rr >= {1'b0, r_root};
    assign q_next  = {r_q[30:0], dv_ok};
    assign lerp    = neg_sel ? (v0_sel - q_next) : (v0_sel + q_next);
    assign acc_end = {2'b00, r_acc} + {1'b0, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= rsp_load || (r_ov && !o_rsp.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= r_count[AW-1:0] - AW'(1);
                        r_dist <= i_req.distance[30:0];
                        r_acc  <= '0;
                        r_ox   <= '0;
                        r_oy   <= '0;
                        unique case (i_req.command)
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_ost   <= ST_OK;
                            end
                            CMD_APPEND: begin
                                if (r_count == CW'(MAX_VERTICES)) begin
                                    r_ost <= ST_FULL;
                                end else begin
                                    r_ost   <= ST_OK;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            CMD_QUERY: begin
                                if (r_count == '0) begin
                                    r_ost <= ST_EMPTY;
                                end else begin
                                    r_ost <= ST_OK;
                                    // negative distance or single vertex: answer is v[0]
                                    if (i_req.distance[31] || r_count == CW'(1)) begin
                                        r_state <= S_RD0;
                                    end else begin
                                        r_state <= S_LOAD0;
                                    end
                                end
                            end
                            default: r_ost <= ST_OK;
                        endcase
                    end
                end
                S_RD0: begin
                    r_rx    <= rd_data[63:32];
                    r_ry    <= rd_data[31:0];
                    r_st    <= ST_OK;
                    r_state <= S_DONE;
                end
                S_LOAD0: begin
                    r_prev_x <= rd_data[63:32];
                    r_prev_y <= rd_data[31:0];
                    r_idx    <= AW'(1);
                    r_state  <= S_LOADN;
                end
                S_LOADN: begin
                    r_cur_x <= rd_data[63:32];
                    r_cur_y <= rd_data[31:0];
                    r_mx    <= abs33(dx_rd);
                    r_my    <= abs33(dy_rd);
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_sq    <= 64'(r_mx) * 64'(r_mx);
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_prod  <= 64'(r_my) * 64'(r_my);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rad   <= {2'b00, r_sq} + {2'b00, r_prod};
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_cnt   <= 6'd32;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rad  <= {r_rad[63:0], 2'b00};
                    r_srem <= sq_ok ? (sq_sh - sq_trial) : sq_sh;
                    r_root <= {root_sh[32:1], sq_ok};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    // r_root holds the segment length
                    if (r_root != '0 && r_acc <= {1'b0, r_dist}
                        && acc_end >= {3'b000, r_dist}) begin
                        r_rem   <= r_dist - r_acc[30:0];
                        r_axis  <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_acc <= acc_end[31:0];
                        if (r_idx == r_last) begin
                            r_rx    <= r_cur_x;
                            r_ry    <= r_cur_y;
                            r_st    <= ST_OK;
                            r_state <= S_DONE;
                        end else begin
                            r_prev_x <= r_cur_x;
                            r_prev_y <= r_cur_y;
                            r_idx    <= r_idx + AW'(1);
                            r_state  <= S_LOADN;
                        end
                    end
                end
                S_MUL: begin
                    r_num   <= 64'(mag_sel) * 64'(r_rem);
                    r_state <= S_ADDH;
                end
                S_ADDH: begin
                    r_num   <= r_num + 64'(r_root[32:1]);
                    r_drem  <= '0;
                    r_q     <= '0;
                    r_cnt   <= 6'd63;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num  <= {r_num[62:0], 1'b0};
                    r_drem <= dv_ok ? 33'(dv_rr - {1'b0, r_root}) : dv_rr[32:0];
                    r_q    <= q_next;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        if (!r_axis) begin
                            r_rx    <= lerp;
                            r_axis  <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_ry    <= lerp;
                            r_st    <= ST_OK;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ox    <= r_rx;
                        r_oy    <= r_ry;
                        r_ost   <= r_st;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid  = r_ov;
    assign o_rsp.out_x  = r_ox;
    assign o_rsp.out_y  = r_oy;
    assign o_rsp.status = r_ost;
endmodule

/* src/pdp_checker.sv */
// Port-level assertions for the polyline point-at-distance block, bound to the top level.
// Depends on pdp_pkg and polyline_point_at_distance.
module pdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_y,
    input logic [1:0]  i_status
);
    import pdp_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == ST_OK || i_status == ST_EMPTY
                         || i_status == ST_FULL))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_OK |-> i_out_x == '0 && i_out_y == '0)
        else $error("error response carries coordinates");

    // next request only alongside draining of the one just answered
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && !(i_rsp_valid && i_rsp_ready)
        |=> !i_req_ready || (i_rsp_valid && i_rsp_ready))
        else $error("request taken while previous one outstanding");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");
endmodule

bind polyline_point_at_distance pdp_checker u_pdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_out_x     (o_rsp.out_x),
    .i_out_y     (o_rsp.out_y),
    .i_status    (o_rsp.status)
);
